// ----- hw/rtl/ppx_pkg.sv -----
// Shared types, fixed-point constants and sine table builder for the plasma pixel block.
// No dependencies; every other file of the block imports this package.
package ppx_pkg;

  // Input and result items
  typedef struct packed {
    logic [4:0]  column;
    logic [5:0]  row;
    logic [15:0] frame;
  } ppx_in_t;

  typedef struct packed {
    logic [5:0] red;
    logic [4:0] green;
    logic [6:0] blue;
  } ppx_out_t;

  // Frame-rate phase terms carried down the pipeline
  typedef struct packed {
    logic [25:0] fk001;
    logic [28:0] fk01;
    logic [27:0] fk005;
  } ppx_phase_t;

  // Datapath widths
  localparam int PPX_ANG_W     = 32;    // Q16 angle
  localparam int PPX_SIN_W     = 18;    // Q16 sine, -1..1
  localparam int PPX_RAD_W     = 46;    // square root radicand
  localparam int PPX_ROOT_W    = PPX_RAD_W / 2;
  localparam int PPX_SINE_DEPTH = 1024;

  // Q16 constants
  localparam int PPX_Q_ONE     = 65536;
  localparam int PPX_HALF_PI   = 102944;
  localparam int PPX_CENTER    = 983040;  // 15.0
  localparam int PPX_K_003     = 1966;
  localparam int PPX_K_004     = 2621;
  localparam int PPX_K_002     = 1311;
  localparam int PPX_K_001     = 655;
  localparam int PPX_K_01      = 6554;
  localparam int PPX_K_005     = 3277;
  localparam logic [13:0] PPX_K_02  = 14'd13107;
  localparam logic [16:0] PPX_K_08  = 17'd52429;
  localparam logic [16:0] PPX_K_13  = 17'd85197;
  localparam logic [16:0] PPX_K_135 = 17'd88474;
  localparam logic [16:0] PPX_K_045 = 17'd29491;
  localparam logic [16:0] PPX_K_04  = 17'd26214;
  localparam logic [29:0] PPX_TURN_SCALE = 30'd683565276;  // 2^32 / 2pi, Q16 in
  localparam longint unsigned PPX_TWO_PI_Q28 = 64'd1686629713;

  // Restoring long division, quotient only; used while building the table
  function automatic longint unsigned ppx_udiv(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One sine table entry: fold into 0..pi, 13-term Taylor series in Q28,
  // round to Q16 and clamp. The table depth is 2^idx_w.
  function automatic logic signed [PPX_SIN_W-1:0] ppx_sine_entry(input int unsigned k,
                                                                 input int unsigned idx_w);
    longint unsigned depth;
    longint unsigned kk;
    longint unsigned x;
    longint unsigned term;
    longint unsigned dv;
    longint          sum;
    bit              neg;
    depth = 64'd1 << idx_w;
    kk    = 64'(k);
    neg   = 1'b0;
    if (2 * kk > depth) begin
      kk  = depth - kk;
      neg = 1'b1;
    end
    x    = (kk * PPX_TWO_PI_Q28) >> idx_w;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = (term * x) >> 28;
      term = (term * x) >> 28;
      dv   = 64'((2 * n) * (2 * n + 1));
      term = ppx_udiv(term, dv);
      if ((n & 1) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 2048) >>> 12;
    if (sum > PPX_Q_ONE) sum = PPX_Q_ONE;
    return neg ? PPX_SIN_W'(-sum) : PPX_SIN_W'(sum);
  endfunction

endpackage

// ----- hw/rtl/ppx_sine.sv -----
// Sine lookup: angle to table index (one multiply), then registered ROM read.
// Depends on ppx_pkg for widths, the turn scale and the table builder.
module ppx_sine import ppx_pkg::*; #(
  parameter int DEPTH = PPX_SINE_DEPTH
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [PPX_ANG_W-1:0] angle,
  output logic signed [PPX_SIN_W-1:0] value
);

  localparam int IDX_W = $clog2(DEPTH);

  logic signed [PPX_SIN_W-1:0] rom [DEPTH];
  logic signed [62:0]          prod;
  logic [IDX_W-1:0]            idx_nxt;
  logic [IDX_W-1:0]            idx_r;
  logic signed [PPX_SIN_W-1:0] val_r;

  // Constant table, one full period
  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam logic signed [PPX_SIN_W-1:0] ENTRY = ppx_sine_entry(i, IDX_W);
    assign rom[i] = ENTRY;
  end

  // Fractional turn in Q32 sits in product bits 47..16; index is its top bits
  assign prod    = angle * $signed({1'b0, PPX_TURN_SCALE});
  assign idx_nxt = prod[47 -: IDX_W];

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r <= idx_nxt;
      val_r <= rom[idx_r];
    end
  end

  assign value = val_r;

endmodule

// ----- hw/rtl/ppx_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, floor of the root.
// Depends on ppx_pkg for the default radicand width.
module ppx_sqrt import ppx_pkg::*; #(
  parameter int IN_W = PPX_RAD_W
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   rad,
  output logic [IN_W/2-1:0] root
);

  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 2;

  logic [REM_W-1:0] rem_r   [OUT_W-1];
  logic [REM_W-1:0] rem_nxt [OUT_W-1];
  logic [IN_W-1:0]  rad_r   [OUT_W-1];
  logic [IN_W-1:0]  rad_nxt [OUT_W-1];
  logic [OUT_W-1:0] root_r   [OUT_W];
  logic [OUT_W-1:0] root_nxt [OUT_W];

  // Restoring step per stage: bring down two radicand bits, try root*4+1
  always_comb begin
    logic [REM_W-1:0] rem_in;
    logic [OUT_W-1:0] root_in;
    logic [IN_W-1:0]  rad_in;
    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    for (int s = 0; s < OUT_W; s++) begin
      if (s == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = rad;
      end else begin
        rem_in  = rem_r[s-1];
        root_in = root_r[s-1];
        rad_in  = rad_r[s-1];
      end
      acc   = {rem_in, rad_in[IN_W-1 -: 2]};
      trial = (REM_W + 2)'({root_in, 2'b01});
      if (acc >= trial) begin
        root_nxt[s] = {root_in[OUT_W-2:0], 1'b1};
        if (s < OUT_W - 1) rem_nxt[s] = REM_W'(acc - trial);
      end else begin
        root_nxt[s] = {root_in[OUT_W-2:0], 1'b0};
        if (s < OUT_W - 1) rem_nxt[s] = REM_W'(acc);
      end
      if (s < OUT_W - 1) rad_nxt[s] = {rad_in[IN_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < OUT_W; s++) root_r[s] <= root_nxt[s];
      for (int s = 0; s < OUT_W - 1; s++) begin
        rem_r[s] <= rem_nxt[s];
        rad_r[s] <= rad_nxt[s];
      end
    end
  end

  assign root = root_r[OUT_W-1];

endmodule

// ----- hw/rtl/plasma_pattern_pixel.sv -----
// Plasma color pipeline top: frame phases, distance fields, level and color ramps.
// Depends on ppx_pkg, ppx_sine and ppx_sqrt.
//
// One pixel item enters per clock and its color is offered through 37 register
// stages (PPX_ROOT_W + 14); the three 23-stage square root pipelines make up
// most of those stages. The datapath is fully pipelined, so the sustained rate
// is one item per cycle; when out_ready is low with a result waiting, the whole
// pipeline holds and in_ready drops in the same cycle. Seven sine tables of
// SINE_TABLE_DEPTH entries (a power of two) are read with a registered port.
// Column and row beyond the panel are computed by the same formulas.
module plasma_pattern_pixel import ppx_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = PPX_SINE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ppx_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ppx_out_t out_data
);

  localparam int PIPE_LEN = PPX_ROOT_W + 14;
  localparam int PH_DLY   = PPX_ROOT_W + 8;

  logic                 en;
  logic [PIPE_LEN-1:0]  vld_r;

  // Global advance: hold everything while a result waits
  assign en        = out_ready || !vld_r[PIPE_LEN-1];
  assign in_ready  = en;
  assign out_valid = vld_r[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LEN-2:0], in_valid};
    end
  end

  // Stage 1: frame phases and scaled positions
  logic [4:0]                 s1_x_r, s2_x_r, s3_x_r;
  logic [5:0]                 s1_y_r, s2_y_r, s3_y_r;
  logic [18:0]                s1_xk_r, s2_xk_r, s3_xk_r;
  logic [19:0]                s1_yk_r, s2_yk_r, s3_yk_r;
  logic signed [PPX_ANG_W-1:0] s1_ac1_r, s1_as1_r, s1_ac2_r;
  ppx_phase_t                 s1_ph_r;
  ppx_phase_t                 ph_dly_r [PH_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r        <= in_data.column;
      s1_y_r        <= in_data.row;
      s1_xk_r       <= 19'(in_data.column * PPX_K_02);
      s1_yk_r       <= 20'(in_data.row * PPX_K_02);
      s1_ac1_r      <= PPX_ANG_W'(32'(in_data.frame) * PPX_K_003 + PPX_HALF_PI);
      s1_as1_r      <= PPX_ANG_W'(32'(in_data.frame) * PPX_K_004);
      s1_ac2_r      <= PPX_ANG_W'(32'(in_data.frame) * PPX_K_002 + PPX_HALF_PI);
      s1_ph_r.fk001 <= 26'(32'(in_data.frame) * PPX_K_001);
      s1_ph_r.fk01  <= 29'(32'(in_data.frame) * PPX_K_01);
      s1_ph_r.fk005 <= 28'(32'(in_data.frame) * PPX_K_005);
      s2_x_r  <= s1_x_r;   s3_x_r  <= s2_x_r;
      s2_y_r  <= s1_y_r;   s3_y_r  <= s2_y_r;
      s2_xk_r <= s1_xk_r;  s3_xk_r <= s2_xk_r;
      s2_yk_r <= s1_yk_r;  s3_yk_r <= s2_yk_r;
      ph_dly_r[0] <= s1_ph_r;
      for (int i = 1; i < PH_DLY; i++) ph_dly_r[i] <= ph_dly_r[i-1];
    end
  end

  // Stages 2-3: frame sines and cosines
  logic signed [PPX_SIN_W-1:0] sin_c1, sin_s1, sin_c2, sin_s2;

  ppx_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_c1 (.clk, .en, .angle(s1_ac1_r), .value(sin_c1));
  ppx_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_s1 (.clk, .en, .angle(s1_as1_r), .value(sin_s1));
  ppx_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_c2 (.clk, .en, .angle(s1_ac2_r), .value(sin_c2));
  ppx_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_s2 (
    .clk, .en, .angle($signed(PPX_ANG_W'(s1_ph_r.fk001))), .value(sin_s2)
  );

  // Stage 4: moving offsets and second-field center distances
  logic signed [37:0] s4_px_r, s4_py_r;
  logic signed [22:0] s4_ex_r;
  logic signed [23:0] s4_ey_r;
  logic signed [37:0] px_nxt, py_nxt;
  logic signed [22:0] ex_nxt;
  logic signed [23:0] ey_nxt;

  assign px_nxt = $signed({1'b0, s3_xk_r}) * sin_c1;
  assign py_nxt = $signed({1'b0, s3_yk_r}) * sin_s1;
  assign ex_nxt = 23'(PPX_CENTER) - $signed({1'b0, s3_x_r}) * sin_c2;
  assign ey_nxt = 24'(PPX_CENTER) - $signed({1'b0, s3_y_r}) * sin_s2;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_px_r <= px_nxt;
      s4_py_r <= py_nxt;
      s4_ex_r <= ex_nxt;
      s4_ey_r <= ey_nxt;
    end
  end

  // Stage 5: squares (first-field offsets are always positive)
  logic signed [21:0] dx, dy;
  logic [20:0]        dx_mag, dy_mag;
  logic [22:0]        ex_mag, ey_mag;
  logic [41:0]        s5_dx2_r, s5_dy2_r;
  logic [45:0]        s5_sx_r, s5_sy_r;

  assign dx     = 22'(PPX_CENTER) - 22'(s4_px_r >>> 16);
  assign dy     = 22'(PPX_CENTER) - 22'(s4_py_r >>> 16);
  assign dx_mag = dx[20:0];
  assign dy_mag = dy[20:0];
  assign ex_mag = s4_ex_r[22] ? 23'(-s4_ex_r) : 23'(s4_ex_r);
  assign ey_mag = s4_ey_r[23] ? 23'(-s4_ey_r) : 23'(s4_ey_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s5_dx2_r <= 42'(dx_mag) * 42'(dx_mag);
      s5_dy2_r <= 42'(dy_mag) * 42'(dy_mag);
      s5_sx_r  <= 46'(ex_mag) * 46'(ex_mag);
      s5_sy_r  <= 46'(ey_mag) * 46'(ey_mag);
    end
  end

  // Stage 6: distance sum and weighted partial products (low/high halves)
  logic [42:0] s6_dsum_r;
  logic [39:0] s6_axl_r, s6_axh_r, s6_ayl_r, s6_ayh_r;
  logic [39:0] s6_bxl_r, s6_bxh_r, s6_byl_r, s6_byh_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_dsum_r <= 43'(s5_dx2_r) + 43'(s5_dy2_r);
      s6_axl_r  <= 40'(s5_sx_r[22:0])  * 40'(PPX_K_08);
      s6_axh_r  <= 40'(s5_sx_r[45:23]) * 40'(PPX_K_08);
      s6_ayl_r  <= 40'(s5_sy_r[22:0])  * 40'(PPX_K_13);
      s6_ayh_r  <= 40'(s5_sy_r[45:23]) * 40'(PPX_K_13);
      s6_bxl_r  <= 40'(s5_sx_r[22:0])  * 40'(PPX_K_135);
      s6_bxh_r  <= 40'(s5_sx_r[45:23]) * 40'(PPX_K_135);
      s6_byl_r  <= 40'(s5_sy_r[22:0])  * 40'(PPX_K_045);
      s6_byh_r  <= 40'(s5_sy_r[45:23]) * 40'(PPX_K_045);
    end
  end

  // Stage 7: sum halves
  logic [42:0] s7_dsum_r;
  logic [40:0] s7_alo_r, s7_ahi_r, s7_blo_r, s7_bhi_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_dsum_r <= s6_dsum_r;
      s7_alo_r  <= 41'(s6_axl_r) + 41'(s6_ayl_r);
      s7_ahi_r  <= 41'(s6_axh_r) + 41'(s6_ayh_r);
      s7_blo_r  <= 41'(s6_bxl_r) + 41'(s6_byl_r);
      s7_bhi_r  <= 41'(s6_bxh_r) + 41'(s6_byh_r);
    end
  end

  // Stage 8: recombine halves, drop Q16 fraction of the weights
  logic [63:0]          qa_full, qb_full;
  logic [PPX_RAD_W-1:0] s8_dsum_r, s8_qa_r, s8_qb_r;

  assign qa_full = (64'(s7_ahi_r) << 23) + 64'(s7_alo_r);
  assign qb_full = (64'(s7_bhi_r) << 23) + 64'(s7_blo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s8_dsum_r <= PPX_RAD_W'(s7_dsum_r);
      s8_qa_r   <= qa_full[61:16];
      s8_qb_r   <= qb_full[61:16];
    end
  end

  // Stages 9-31: square roots
  logic [PPX_ROOT_W-1:0] root_d, root_a, root_b;

  ppx_sqrt #(.IN_W(PPX_RAD_W)) u_sqrt_d (.clk, .en, .rad(s8_dsum_r), .root(root_d));
  ppx_sqrt #(.IN_W(PPX_RAD_W)) u_sqrt_a (.clk, .en, .rad(s8_qa_r),   .root(root_a));
  ppx_sqrt #(.IN_W(PPX_RAD_W)) u_sqrt_b (.clk, .en, .rad(s8_qb_r),   .root(root_b));

  // Stage 32: scale distances by 0.2
  logic [36:0] s32_mb_r, s32_m1_r, s32_m2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s32_mb_r <= 37'(root_d) * 37'(PPX_K_02);
      s32_m1_r <= 37'(root_a) * 37'(PPX_K_02);
      s32_m2_r <= 37'(root_b) * 37'(PPX_K_02);
    end
  end

  // Stage 33: combine with frame phases (subtract for the distance field, add for the other two)
  ppx_phase_t                  ph_late;
  logic signed [PPX_ANG_W-1:0] s33_ab_r, s33_a1_r, s33_a2_r;

  assign ph_late = ph_dly_r[PH_DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      s33_ab_r <= $signed(32'(s32_mb_r[36:16]) - 32'(ph_late.fk001));
      s33_a1_r <= $signed(32'(s32_m1_r[36:16]) + 32'(ph_late.fk01));
      s33_a2_r <= $signed(32'(s32_m2_r[36:16]) + 32'(ph_late.fk005));
    end
  end

  // Stages 34-35: field sines
  logic signed [PPX_SIN_W-1:0] sin_b, sin_h1, sin_h2;

  ppx_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_b  (.clk, .en, .angle(s33_ab_r), .value(sin_b));
  ppx_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_h1 (.clk, .en, .angle(s33_a1_r), .value(sin_h1));
  ppx_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_h2 (.clk, .en, .angle(s33_a2_r), .value(sin_h2));

  // Stage 36: level = (2*(1+sb) + 2 + s1 + s2) / 8, clamped at zero
  logic signed [20:0] lvl_sum;
  logic [16:0]        s36_lvl_r;

  assign lvl_sum = 21'(4 * PPX_Q_ONE) + 21'(2 * sin_b) + 21'(sin_h1) + 21'(sin_h2);

  always_ff @(posedge clk) begin
    if (en) begin
      s36_lvl_r <= lvl_sum[20] ? '0 : lvl_sum[19:3];
    end
  end

  // Stage 37: color ramps, then halve
  logic [24:0] ramp_b, ramp_r, ramp_g;
  logic [7:0]  blue8, red8, green8;
  ppx_out_t    out_r;

  always_comb begin
    ramp_b = 25'(s36_lvl_r) * 25'd200;
    ramp_r = 25'(s36_lvl_r - PPX_K_04) * 25'd200;
    ramp_g = 25'(s36_lvl_r - PPX_K_08) * 25'd255;
    blue8  = 8'd55;
    red8   = '0;
    green8 = '0;
    if (s36_lvl_r < 17'(PPX_Q_ONE)) begin
      blue8 = 8'd55 + ramp_b[23:16];
      if (s36_lvl_r >= PPX_K_04) red8   = ramp_r[23:16];
      if (s36_lvl_r >= PPX_K_08) green8 = ramp_g[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.red   <= red8[6:1];
      out_r.green <= green8[5:1];
      out_r.blue  <= blue8[7:1];
    end
  end

  assign out_data = out_r;

endmodule

// ----- hw/rtl/ppx_checker.sv -----
// Port-level checks for the plasma pixel top, attached with a bind.
// Depends on ppx_pkg for the item types.
module ppx_checker import ppx_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input ppx_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input ppx_out_t out_data
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item after reset");

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Input is taken whenever no result is stuck
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with output free");

  // Blue never drops below its floor
  a_blue_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.blue >= 7'd27)
    else $error("blue below floor");

  // Green ramp opens above the red one
  a_green_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.green != 5'd0 |-> out_data.red >= 6'd40)
    else $error("green without red");

endmodule

bind plasma_pattern_pixel ppx_checker u_ppx_checker (.*);
